// File: src/esploop_pkg.sv
`default_nettype none

package esploop_pkg;

  // item codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  localparam int POS_W = 32;
  localparam int IVL_W = 16;

  localparam logic [IVL_W-1:0] STEP_INTERVAL_RESET = 16'd1000;

  typedef struct packed {
    logic                    opcode;
    logic                    enc_a;
    logic                    enc_b;
    logic signed [POS_W-1:0] target;
  } in_item_t;

  typedef struct packed {
    logic                    step_pulse;
    logic                    step_dir;
    logic                    is_moving;
    logic signed [POS_W-1:0] position;
  } out_item_t;

endpackage

`default_nettype wire

// File: src/encoder_stepper_position_loop_top.sv
`default_nettype none

// Quadrature x4 encoder decoder with a constant-rate stepper position loop.
// Each input transaction is either a one-microsecond tick carrying the
// sampled encoder A/B levels (opcode OP_TICK) or a move command carrying a
// signed target position (opcode OP_MOVE). Every input transaction yields
// exactly one output transaction holding the step pulse, the held direction
// line, the moving flag and the encoder position after that item. A tick
// decodes A/B against the previous sample (A change counts up when A == B,
// B change counts up when A != B, both changing counts nothing), advances a
// tick counter that saturates at step_interval, and during a move either
// ends the move (target within +-1 count) or issues a step towards the
// target once the counter has reached the interval, clearing the counter.
// Position wraps at 32 bits. Throughput is one transaction per clock while
// in_stall is low: all state is updated in the accepting cycle by a single
// pass of logic (one 32-bit increment/decrement followed by one 32-bit
// subtract and compare), and the result lands in an output register backed
// by one skid entry; in_stall only rises once a stalled result sits in the
// output register with a second one held in the skid entry.
// step_interval is written through the cfg port (always ready) and must
// only be changed while the block is idle. Reset is synchronous, active
// high; step_interval resets to 1000.
module encoder_stepper_position_loop_top (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire esploop_pkg::in_item_t           in_data,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output esploop_pkg::out_item_t               out_data,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire [esploop_pkg::IVL_W-1:0]         cfg_data
);
  import esploop_pkg::*;

  // configuration
  logic [IVL_W-1:0] step_interval;

  // loop state
  logic [POS_W-1:0] enc_position;
  logic [POS_W-1:0] goal_position;
  logic             move_active;
  logic [IVL_W-1:0] ticks_since_step;
  logic             prev_a;
  logic             prev_b;
  logic             dir_line;

  logic [POS_W-1:0] enc_position_next;
  logic [POS_W-1:0] goal_position_next;
  logic             move_active_next;
  logic [IVL_W-1:0] ticks_since_step_next;
  logic             prev_a_next;
  logic             prev_b_next;
  logic             dir_line_next;
  logic             pulse;

  // decode / control helpers
  logic             a_changed;
  logic             b_changed;
  logic [POS_W-1:0] diff;
  logic             near;
  logic [IVL_W-1:0] ticks_sat;

  // output register plus skid entry
  logic      skid_valid;
  out_item_t skid_data;
  out_item_t result;
  logic      accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;

  always_comb begin
    enc_position_next     = enc_position;
    goal_position_next    = goal_position;
    move_active_next      = move_active;
    ticks_since_step_next = ticks_since_step;
    prev_a_next           = prev_a;
    prev_b_next           = prev_b;
    dir_line_next         = dir_line;
    pulse                 = 1'b0;

    a_changed = in_data.enc_a != prev_a;
    b_changed = in_data.enc_b != prev_b;

    // saturating counter: below the interval count up, otherwise take the interval
    ticks_sat = (ticks_since_step >= step_interval) ? step_interval
                                                    : ticks_since_step + 1'b1;

    diff = '0;
    near = 1'b0;

    case (in_data.opcode)
      OP_MOVE: begin
        goal_position_next = in_data.target;
        move_active_next   = 1'b1;
      end
      OP_TICK: begin
        if (a_changed && !b_changed) begin
          enc_position_next = (in_data.enc_a == in_data.enc_b) ? enc_position + 1'b1
                                                               : enc_position - 1'b1;
        end else if (b_changed && !a_changed) begin
          enc_position_next = (in_data.enc_a != in_data.enc_b) ? enc_position + 1'b1
                                                               : enc_position - 1'b1;
        end
        prev_a_next           = in_data.enc_a;
        prev_b_next           = in_data.enc_b;
        ticks_since_step_next = ticks_sat;

        diff = goal_position - enc_position_next;
        near = (diff == '0) || (diff == POS_W'(1)) || (diff == '1);

        if (move_active) begin
          if (near) begin
            move_active_next = 1'b0;
          end else if (ticks_sat >= step_interval) begin
            ticks_since_step_next = '0;
            dir_line_next         = ~diff[POS_W-1];  // sign of error
            pulse                 = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    result.step_pulse = pulse;
    result.step_dir   = dir_line_next;
    result.is_moving  = move_active_next;
    result.position   = enc_position_next;
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval    <= STEP_INTERVAL_RESET;
      enc_position     <= '0;
      goal_position    <= '0;
      move_active      <= 1'b0;
      ticks_since_step <= '0;
      prev_a           <= 1'b1;
      prev_b           <= 1'b1;
      dir_line         <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_interval <= cfg_data;
      end
      if (accept) begin
        enc_position     <= enc_position_next;
        goal_position    <= goal_position_next;
        move_active      <= move_active_next;
        ticks_since_step <= ticks_since_step_next;
        prev_a           <= prev_a_next;
        prev_b           <= prev_b_next;
        dir_line         <= dir_line_next;
      end
    end
  end

  // output register with one skid entry; skid drains first to keep order
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else if (accept) begin
          out_data  <= result;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (accept) begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: dv/encoder_stepper_position_loop_top_tb.sv
`timescale 1ns / 100ps

module encoder_stepper_position_loop_top_tb;
  import esploop_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IVL_W-1:0]     cfg_data  = '0;

  encoder_stepper_position_loop_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_item_t  cmd_queue [$];   // transactions waiting to be driven
  out_item_t status_due [$];  // status the block owes us, oldest first
  int        mismatches = 0;

  // idle / stall likelihood in percent, changed per phase
  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;

  // ---------------------------------------------------------------------
  // Loop model: mirrors the block's state and interval register
  // ---------------------------------------------------------------------
  logic [POS_W-1:0] mdl_pos    = '0;
  logic [POS_W-1:0] mdl_goal   = '0;
  logic             mdl_moving = 1'b0;
  logic [IVL_W-1:0] mdl_ticks  = '0;
  logic             mdl_prev_a = 1'b1;  // encoder lines idle high
  logic             mdl_prev_b = 1'b1;
  logic             mdl_dir    = 1'b1;
  logic [IVL_W-1:0] step_ivl   = STEP_INTERVAL_RESET;

  // x4 decode: A edge counts up when A == B afterwards, B edge counts up
  // when they differ, both edges at once are ambiguous and count nothing.
  function automatic int quad_step(input logic pa, input logic pb,
                                   input logic a, input logic b);
    if ((a != pa) && (b == pb))
      return (a == b) ? 1 : -1;
    if ((b != pb) && (a == pa))
      return (a != b) ? 1 : -1;
    return 0;
  endfunction

  task automatic advance_loop(input in_item_t it, output out_item_t st);
    logic [POS_W-1:0] err;
    logic             pulse;
    pulse = 1'b0;
    if (it.opcode == OP_MOVE) begin
      // new goal, no decode and no counter activity on this transaction
      mdl_goal   = it.target;
      mdl_moving = 1'b1;
    end else begin
      mdl_pos    = mdl_pos + 32'(quad_step(mdl_prev_a, mdl_prev_b, it.enc_a, it.enc_b));
      mdl_prev_a = it.enc_a;
      mdl_prev_b = it.enc_b;
      // counter runs even while idle and saturates; clamp covers an
      // interval lowered underneath it
      if (mdl_ticks < step_ivl)
        mdl_ticks = mdl_ticks + 1'b1;
      if (mdl_ticks > step_ivl)
        mdl_ticks = step_ivl;
      if (mdl_moving) begin
        err = mdl_goal - mdl_pos;
        if (err == '0 || err == 32'd1 || err == '1) begin
          mdl_moving = 1'b0;
        end else if (mdl_ticks >= step_ivl) begin
          mdl_ticks = '0;
          mdl_dir   = ~err[POS_W-1];  // -2^31 reads as negative: step down
          pulse     = 1'b1;
        end
      end
    end
    st.step_pulse = pulse;
    st.step_dir   = mdl_dir;
    st.is_moving  = mdl_moving;
    st.position   = mdl_pos;
  endtask

  // ---------------------------------------------------------------------
  // Driver: takes from cmd_queue, predicts on acceptance
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drv
    out_item_t st;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_loop(in_data, st);
        status_due.push_back(st);
      end
      // payload only moves once the current one has gone
      if (!in_valid || !in_stall) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= cmd_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks every accepted output transaction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : mon
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          $error("unexpected output transaction, position %0d", out_data.position);
          mismatches++;
        end else begin
          want = status_due.pop_front();
          if (out_data.step_pulse !== want.step_pulse) begin
            $error("step_pulse: expected %0d, got %0d", want.step_pulse,
                   out_data.step_pulse);
            mismatches++;
          end
          if (out_data.step_dir !== want.step_dir) begin
            $error("step_dir: expected %0d, got %0d", want.step_dir, out_data.step_dir);
            mismatches++;
          end
          if (out_data.is_moving !== want.is_moving) begin
            $error("is_moving: expected %0d, got %0d", want.is_moving,
                   out_data.is_moving);
            mismatches++;
          end
          if (out_data.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_data.position);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus generation. The generator keeps its own idea of where the
  // encoder is, so it can walk the lines towards the goal like a motor
  // following its steps; that way moves actually finish.
  // ---------------------------------------------------------------------
  logic [POS_W-1:0] gen_pos  = '0;
  logic [POS_W-1:0] gen_goal = '0;
  logic             gen_a    = 1'b1;
  logic             gen_b    = 1'b1;

  task automatic push_tick(input logic a, input logic b);
    in_item_t it;
    it.opcode = OP_TICK;
    it.enc_a  = a;
    it.enc_b  = b;
    it.target = $urandom;  // ignored on a tick
    gen_pos   = gen_pos + 32'(quad_step(gen_a, gen_b, a, b));
    gen_a     = a;
    gen_b     = b;
    cmd_queue.push_back(it);
  endtask

  task automatic push_move(input logic [POS_W-1:0] goal);
    in_item_t it;
    it.opcode = OP_MOVE;
    it.enc_a  = 1'($urandom_range(1));  // ignored on a move
    it.enc_b  = 1'($urandom_range(1));
    it.target = goal;
    gen_goal  = goal;
    cmd_queue.push_back(it);
  endtask

  task automatic rand_item();
    int               r;
    logic             up;
    logic [POS_W-1:0] err;
    r = $urandom_range(99);
    if (r < 5) begin
      r = $urandom_range(99);
      if (r < 55)
        push_move(gen_pos + 32'(int'($urandom_range(60)) - 30));
      else if (r < 75)
        push_move(gen_pos + 32'(int'($urandom_range(2)) - 1));  // already there
      else if (r < 85)
        push_move(gen_pos ^ 32'h8000_0000);  // error of exactly -2^31
      else
        push_move($urandom);
    end else if (r < 10) begin
      push_tick(~gen_a, ~gen_b);  // both lines at once
    end else if (r < 18) begin
      push_tick(gen_a, gen_b);    // no edge
    end else begin
      err = gen_goal - gen_pos;
      up  = (r < 30) ? logic'($urandom_range(1)) : ~err[POS_W-1];
      // toggling A or B moves the count in opposite ways; pick the one
      // that heads where we want
      if ((quad_step(gen_a, gen_b, ~gen_a, gen_b) > 0) == up)
        push_tick(~gen_a, gen_b);
      else
        push_tick(gen_a, ~gen_b);
    end
  endtask

  // Wait until the block holds nothing, then let the clock run on for luck.
  // Sampled on the falling edge so that the queues and in_valid have
  // settled after the rising edge's updates.
  task automatic drain();
    @(negedge clk);
    while (cmd_queue.size() != 0 || in_valid || status_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_interval(input logic [IVL_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    step_ivl = v;
  endtask

  // interval per random phase: extremes, zero and a few small values
  logic [IVL_W-1:0] ivl_plan [12] = '{16'd1, 16'd0, 16'd2, 16'd65535, 16'd3, 16'd1,
                                      16'd7, 16'd0, 16'd65535, 16'd1, 16'd4, 16'd2};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: every A/B transition from the idle-high state, both-edge
    // cases, goals at and next to the position, the -2^31 error and the
    // target extremes. Runs at the reset interval.
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b1);
    push_move(gen_pos);
    push_tick(1'b1, 1'b1);
    push_move(gen_pos + 32'd1);
    push_tick(1'b1, 1'b1);
    push_move(gen_pos - 32'd1);
    push_tick(1'b1, 1'b1);
    push_move(gen_pos ^ 32'h8000_0000);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_move(32'h7fff_ffff);
    push_tick(1'b0, 1'b0);
    push_move(32'h8000_0000);
    push_tick(1'b1, 1'b0);

    // Random phases. Each one first lets the block empty out (the sender
    // holds off until every status has come back), then rewrites the
    // interval and picks a handshake mode.
    for (int p = 0; p < 12; p++) begin
      drain();
      write_interval(ivl_plan[p]);
      case (p % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 55; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 55; end
        default: begin snd_idle_pct = 12; rcv_stall_pct = 12; end
      endcase
      for (int i = 0; i < 128; i++)
        rand_item();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && status_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
